FILE: hdl/acc_step_pkg.sv
// Shared types and constants for the accelerometer step detector.
// Holds the sample, filtered-item and result types and the register indexes.
// No dependencies.
`default_nettype none

package acc_step_pkg;

  localparam int NUM_AXES    = 3;
  localparam int SAMPLE_W    = 16;
  localparam int FILTER_TAPS = 4;
  localparam int TAP_PTR_W   = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
  localparam int SUM_W       = SAMPLE_W + $clog2(FILTER_TAPS);
  localparam int AXIS_W      = 2;
  localparam int POS_W       = 8;
  localparam int MIN_P2P_W   = 16;
  localparam int STEPS_W     = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_P2P    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd1;

  localparam logic [MIN_P2P_W-1:0] MIN_P2P_RESET = 16'd3000;
  localparam logic [POS_W-1:0]     WINDOW_RESET  = 8'd50;

  localparam logic [AXIS_W-1:0] NO_AXIS = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t THR_NONE    = 16'sh7FFF;
  localparam sample_t PEAK_INIT   = 16'sh8000;
  localparam sample_t TROUGH_INIT = 16'sh7FFF;

  typedef struct packed {
    sample_t [NUM_AXES-1:0] axis;
  } filt_t;

  typedef struct packed {
    sample_t [NUM_AXES-1:0] filt;
    logic                   step_seen;
    logic [STEPS_W-1:0]     total_steps;
    logic                   window_done;
    logic [AXIS_W-1:0]      watched_axis;
    sample_t                watched_threshold;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/acc_step_fifo.sv
// Small register queue used between the filter and detector and on the result side.
// Generic in width and depth; no package dependency.
`default_nettype none

module acc_step_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/acc_step_filter.sv
// Front end: accepts raw three-axis samples and applies the moving-average filter.
// Depends on acc_step_pkg; pushes filtered items into the middle queue.
`default_nettype none

module acc_step_filter import acc_step_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_push,
  input  wire sample_t in_accel_x,
  input  wire sample_t in_accel_y,
  input  wire sample_t in_accel_z,
  input  wire logic    q_full,
  output logic         q_push,
  output filt_t        q_item
);

  sample_t               tap_r [NUM_AXES][FILTER_TAPS];
  logic [TAP_PTR_W-1:0]  ptr_r, ptr_nxt;
  sample_t               raw [NUM_AXES];
  sample_t               tap_now [NUM_AXES][FILTER_TAPS];
  logic signed [SUM_W-1:0] sum [NUM_AXES];
  logic                  accept;

  assign raw[0] = in_accel_x;
  assign raw[1] = in_accel_y;
  assign raw[2] = in_accel_z;

  assign accept = in_push && !q_full;
  assign q_push = accept;
  assign ptr_nxt = (ptr_r == TAP_PTR_W'(FILTER_TAPS - 1)) ? '0 : ptr_r + 1'b1;

  // The new sample takes the place of the oldest tap before the sum is formed.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum[a] = '0;
      for (int t = 0; t < FILTER_TAPS; t++) begin
        tap_now[a][t] = (ptr_r == TAP_PTR_W'(t)) ? raw[a] : tap_r[a][t];
        sum[a] = sum[a] + {{(SUM_W - SAMPLE_W){tap_now[a][t][SAMPLE_W-1]}}, tap_now[a][t]};
      end
      // Signed division truncates toward zero, as the filter requires.
      q_item.axis[a] = SAMPLE_W'(sum[a] / FILTER_TAPS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int t = 0; t < FILTER_TAPS; t++) begin
          tap_r[a][t] <= '0;
        end
      end
    end else if (accept) begin
      ptr_r <= ptr_nxt;
      for (int a = 0; a < NUM_AXES; a++) begin
        tap_r[a] <= tap_now[a];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/acc_step_detect.sv
// Back end: crossing detection, window extremes, threshold update and step count.
// Depends on acc_step_pkg; pops filtered items and pushes one result per item.
`default_nettype none

module acc_step_detect import acc_step_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [MIN_P2P_W-1:0] min_p2p,
  input  wire logic [POS_W-1:0]     window_len,
  input  wire logic                 q_empty,
  input  wire filt_t                q_item,
  output logic                      q_pop,
  input  wire logic                 out_full,
  output logic                      out_push,
  output result_t                   out_item
);

  sample_t              prev_r [NUM_AXES];
  sample_t              peak_r [NUM_AXES];
  sample_t              trough_r [NUM_AXES];
  logic [AXIS_W-1:0]    act_axis_r, act_axis_nxt;
  sample_t              act_thr_r, act_thr_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [STEPS_W-1:0]   steps_r, steps_nxt;

  sample_t              filt [NUM_AXES];
  sample_t              peak_upd [NUM_AXES];
  sample_t              trough_upd [NUM_AXES];
  sample_t              peak_nxt [NUM_AXES];
  sample_t              trough_nxt [NUM_AXES];
  logic signed [SAMPLE_W:0] swing [NUM_AXES];
  logic signed [SAMPLE_W:0] thr_ext [NUM_AXES];
  logic                 qualify [NUM_AXES];
  logic                 fire;
  logic                 step;
  logic                 close;
  logic [POS_W-1:0]     pos_inc;
  logic                 found;
  sample_t              best;
  logic [AXIS_W-1:0]    best_axis;

  assign fire     = !q_empty && !out_full;
  assign q_pop    = fire;
  assign out_push = fire;

  always_comb begin
    step = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      filt[a] = q_item.axis[a];
      if ((act_axis_r == AXIS_W'(a)) && (filt[a] >= act_thr_r) && (prev_r[a] < act_thr_r)) begin
        step = 1'b1;
      end
      peak_upd[a]   = (filt[a] > peak_r[a]) ? filt[a] : peak_r[a];
      trough_upd[a] = (filt[a] < trough_r[a]) ? filt[a] : trough_r[a];
    end

    pos_inc = pos_r + 1'b1;
    close   = (pos_inc == window_len);

    // Threshold selection over the extremes that include this sample.
    found     = 1'b0;
    best      = THR_NONE;
    best_axis = NO_AXIS;
    for (int a = 0; a < NUM_AXES; a++) begin
      swing[a]   = {peak_upd[a][SAMPLE_W-1], peak_upd[a]}
                 - {trough_upd[a][SAMPLE_W-1], trough_upd[a]};
      qualify[a] = (swing[a] >= $signed({1'b0, min_p2p}));
      thr_ext[a] = {peak_upd[a][SAMPLE_W-1], peak_upd[a]} - (swing[a] / 17'sd4);
      if (qualify[a] && (!found || ($signed(thr_ext[a][SAMPLE_W-1:0]) > best))) begin
        found     = 1'b1;
        best      = thr_ext[a][SAMPLE_W-1:0];
        best_axis = AXIS_W'(a);
      end
    end

    steps_nxt = steps_r + {{(STEPS_W - 1){1'b0}}, step};
    if (close) begin
      pos_nxt      = '0;
      act_axis_nxt = found ? best_axis : NO_AXIS;
      act_thr_nxt  = found ? best : THR_NONE;
      for (int a = 0; a < NUM_AXES; a++) begin
        peak_nxt[a]   = PEAK_INIT;
        trough_nxt[a] = TROUGH_INIT;
      end
    end else begin
      pos_nxt      = pos_inc;
      act_axis_nxt = act_axis_r;
      act_thr_nxt  = act_thr_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        peak_nxt[a]   = peak_upd[a];
        trough_nxt[a] = trough_upd[a];
      end
    end

    for (int a = 0; a < NUM_AXES; a++) begin
      out_item.filt[a] = filt[a];
    end
    out_item.step_seen         = step;
    out_item.total_steps       = steps_nxt;
    out_item.window_done       = close;
    out_item.watched_axis      = act_axis_nxt;
    out_item.watched_threshold = act_thr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_axis_r <= NO_AXIS;
      act_thr_r  <= THR_NONE;
      pos_r      <= '0;
      steps_r    <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        prev_r[a]   <= '0;
        peak_r[a]   <= PEAK_INIT;
        trough_r[a] <= TROUGH_INIT;
      end
    end else if (fire) begin
      act_axis_r <= act_axis_nxt;
      act_thr_r  <= act_thr_nxt;
      pos_r      <= pos_nxt;
      steps_r    <= steps_nxt;
      for (int a = 0; a < NUM_AXES; a++) begin
        prev_r[a]   <= filt[a];
        peak_r[a]   <= peak_nxt[a];
        trough_r[a] <= trough_nxt[a];
      end
    end
  end

  // With no axis armed the threshold must sit at its idle value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (act_axis_r == NO_AXIS) |-> (act_thr_r == THR_NONE))
    else $error("idle axis with a live threshold");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_item.step_seen) |-> (act_axis_r != NO_AXIS))
    else $error("step counted with no axis armed");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_item.step_seen) |=> (steps_r == $past(steps_r) + 32'd1))
    else $error("step total did not advance");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_item.window_done) |=> (pos_r == '0))
    else $error("window position not cleared at window close");

endmodule

`default_nettype wire

FILE: hdl/accel_step_detector_core.sv
// Step detector for three-axis accelerometer samples: top level.
// Uses acc_step_pkg, acc_step_filter, acc_step_fifo and acc_step_detect.
//
// Usage:
//   Samples enter through a queue-style port: in_accel_x/y/z are transferred
//   at a rising edge with in_push high and in_full low. Each sample yields one
//   result, shown on the out_ ports while out_empty is low and transferred at
//   an edge with out_pop high. Results come out in sample order.
//   The two registers are written through cfg_we, cfg_index and cfg_data
//   (index 0: minimum peak-to-peak swing, index 1: window length, low byte);
//   the user must write them only while no sample is in flight; nothing checks it.
// Timing:
//   A sample passes through the filter, the middle queue, the detector and the
//   output queue. One sample per cycle is sustained while out_pop stays high;
//   the limit is the detector's update of thresholds, extremes and step count,
//   which every sample must pass before the next one.
// Reset (rst_n low at a clock edge) clears the filter taps, both queues, the
//   window state, the step total and the registers to their defaults.
// When the receiver stalls, results collect in the output queue, then in the
//   middle queue, and in_full rises once both are full; nothing is dropped.
`default_nettype none

module accel_step_detector_core import acc_step_pkg::*; #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire sample_t               in_accel_x,
  input  wire sample_t               in_accel_y,
  input  wire sample_t               in_accel_z,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output sample_t                    out_filtered_x,
  output sample_t                    out_filtered_y,
  output sample_t                    out_filtered_z,
  output logic                       out_step_seen,
  output logic [STEPS_W-1:0]         out_total_steps,
  output logic                       out_window_done,
  output logic [AXIS_W-1:0]          out_watched_axis,
  output sample_t                    out_watched_threshold,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FILT_BITS = $bits(filt_t);
  localparam int RES_BITS  = $bits(result_t);

  logic [MIN_P2P_W-1:0] min_p2p_r;
  logic [POS_W-1:0]     win_len_r;

  logic                 mid_push, mid_full, mid_pop, mid_empty;
  filt_t                mid_wr_item, mid_rd_item;
  logic [FILT_BITS-1:0] mid_rdata;

  logic                 res_push, res_full;
  result_t              res_wr_item, res_rd_item;
  logic [RES_BITS-1:0]  res_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_p2p_r <= MIN_P2P_RESET;
      win_len_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_P2P:    min_p2p_r <= cfg_data[MIN_P2P_W-1:0];
        REG_WINDOW_LEN: win_len_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  acc_step_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .q_full     (mid_full),
    .q_push     (mid_push),
    .q_item     (mid_wr_item)
  );

  assign in_full = mid_full;

  acc_step_fifo #(
    .WIDTH (FILT_BITS),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_rd_item = filt_t'(mid_rdata);

  acc_step_detect u_detect (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_p2p    (min_p2p_r),
    .window_len (win_len_r),
    .q_empty    (mid_empty),
    .q_item     (mid_rd_item),
    .q_pop      (mid_pop),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_item   (res_wr_item)
  );

  acc_step_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr_item),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_rd_item           = result_t'(res_rdata);
  assign out_filtered_x        = res_rd_item.filt[0];
  assign out_filtered_y        = res_rd_item.filt[1];
  assign out_filtered_z        = res_rd_item.filt[2];
  assign out_step_seen         = res_rd_item.step_seen;
  assign out_total_steps       = res_rd_item.total_steps;
  assign out_window_done       = res_rd_item.window_done;
  assign out_watched_axis      = res_rd_item.watched_axis;
  assign out_watched_threshold = res_rd_item.watched_threshold;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for accel_step_detector_core, the accelerometer step detector.
// It predicts every result in step with the accepted samples and compares each field.
// Depends on acc_step_pkg and the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import acc_step_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int IDLE_PERCENT = 7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  sample_t               in_accel_x = '0;
  sample_t               in_accel_y = '0;
  sample_t               in_accel_z = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  sample_t               out_filtered_x;
  sample_t               out_filtered_y;
  sample_t               out_filtered_z;
  logic                  out_step_seen;
  logic [STEPS_W-1:0]    out_total_steps;
  logic                  out_window_done;
  logic [AXIS_W-1:0]     out_watched_axis;
  sample_t               out_watched_threshold;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_P2P;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: filter taps, crossing history, window extremes and thresholds.
  sample_t               taps [NUM_AXES][FILTER_TAPS];
  logic [TAP_PTR_W-1:0]  tap_slot;
  sample_t               prev_filt [NUM_AXES];
  sample_t               peak_f [NUM_AXES];
  sample_t               trough_f [NUM_AXES];
  logic [AXIS_W-1:0]     watch_axis;
  sample_t               watch_thr;
  logic [POS_W-1:0]      win_pos;
  logic [POS_W-1:0]      win_len;
  logic [MIN_P2P_W-1:0]  min_swing;
  logic [STEPS_W-1:0]    step_count;

  result_t pending_results [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      steady_in = 1'b0;
  bit      steady_out = 1'b0;

  accel_step_detector_core u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_accel_x            (in_accel_x),
    .in_accel_y            (in_accel_y),
    .in_accel_z            (in_accel_z),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_filtered_x        (out_filtered_x),
    .out_filtered_y        (out_filtered_y),
    .out_filtered_z        (out_filtered_z),
    .out_step_seen         (out_step_seen),
    .out_total_steps       (out_total_steps),
    .out_window_done       (out_window_done),
    .out_watched_axis      (out_watched_axis),
    .out_watched_threshold (out_watched_threshold),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_pop <= rst_n && (steady_out || $urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic reset_predictor();
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int t = 0; t < FILTER_TAPS; t++) taps[a][t] = '0;
      prev_filt[a] = '0;
      peak_f[a]    = PEAK_INIT;
      trough_f[a]  = TROUGH_INIT;
    end
    tap_slot   = '0;
    watch_axis = NO_AXIS;
    watch_thr  = THR_NONE;
    win_pos    = '0;
    win_len    = WINDOW_RESET;
    min_swing  = MIN_P2P_RESET;
    step_count = '0;
  endtask

  function automatic result_t predict_step_result(sample_t sx, sample_t sy, sample_t sz);
    result_t           r;
    sample_t           raw [NUM_AXES];
    sample_t           filt;
    int                sum;
    int                swing;
    int                thr;
    int                best;
    logic [AXIS_W-1:0] best_axis;
    logic [POS_W-1:0]  next_pos;
    bit                stepped;
    raw[0]  = sx;
    raw[1]  = sy;
    raw[2]  = sz;
    stepped = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      taps[a][tap_slot] = raw[a];
      sum = 0;
      for (int t = 0; t < FILTER_TAPS; t++) sum += taps[a][t];
      // Integer division here truncates toward zero, which is what the filter does.
      filt = sample_t'(sum / FILTER_TAPS);
      if (watch_axis == a && filt >= watch_thr && prev_filt[a] < watch_thr) stepped = 1'b1;
      if (filt > peak_f[a]) peak_f[a] = filt;
      if (filt < trough_f[a]) trough_f[a] = filt;
      prev_filt[a] = filt;
      r.filt[a]    = filt;
    end
    tap_slot = tap_slot + 1'b1;
    if (stepped) step_count = step_count + 1'b1;

    // The position counter is eight bits wide, so a length of zero means 256 samples.
    next_pos = win_pos + 1'b1;
    r.window_done = (next_pos == win_len);
    if (r.window_done) begin
      win_pos   = '0;
      best      = 0;
      best_axis = NO_AXIS;
      for (int a = 0; a < NUM_AXES; a++) begin
        swing = int'(peak_f[a]) - int'(trough_f[a]);
        if (swing >= int'(min_swing)) begin
          thr = int'(peak_f[a]) - swing / 4;
          // A strict comparison leaves ties with the lower axis.
          if (best_axis == NO_AXIS || thr > best) begin
            best      = thr;
            best_axis = AXIS_W'(a);
          end
        end
        peak_f[a]   = PEAK_INIT;
        trough_f[a] = TROUGH_INIT;
      end
      watch_axis = best_axis;
      watch_thr  = (best_axis == NO_AXIS) ? THR_NONE : sample_t'(best);
    end else begin
      win_pos = next_pos;
    end
    r.step_seen         = stepped;
    r.total_steps       = step_count;
    r.watched_axis      = watch_axis;
    r.watched_threshold = watch_thr;
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no result expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("filtered_x", sample_t'(want.filt[0]), out_filtered_x);
        compare_field("filtered_y", sample_t'(want.filt[1]), out_filtered_y);
        compare_field("filtered_z", sample_t'(want.filt[2]), out_filtered_z);
        compare_field("step_seen", want.step_seen, out_step_seen);
        compare_field("total_steps", want.total_steps, out_total_steps);
        compare_field("window_done", want.window_done, out_window_done);
        compare_field("watched_axis", want.watched_axis, out_watched_axis);
        compare_field("watched_threshold", sample_t'(want.watched_threshold),
                      out_watched_threshold);
      end
    end
  end

  // Leaves in_push high after the transfer so that back-to-back samples need no gap.
  task automatic send_sample(sample_t sx, sample_t sy, sample_t sz);
    while (!steady_in && $urandom_range(99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_accel_x <= sx;
    in_accel_y <= sy;
    in_accel_z <= sz;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_results.push_back(predict_step_result(sx, sy, sz));
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_registers(logic [CFG_DATA_W-1:0] swing, logic [CFG_DATA_W-1:0] window_word);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_P2P;
    cfg_data  <= swing;
    @(posedge clk);
    cfg_index <= REG_WINDOW_LEN;
    cfg_data  <= window_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_swing = swing;
    win_len   = window_word[POS_W-1:0];
  endtask

  // Walking-like motion: a triangle wave led by one axis, with jitter, and now and
  // then a burst of unrelated noise.
  task automatic send_gait(int count);
    int      seg_left;
    int      lead;
    int      period;
    int      offset;
    int      spread;
    int      phase;
    int      wave;
    int      v;
    int      amp [NUM_AXES];
    bit      noisy;
    sample_t s [NUM_AXES];
    seg_left = 0;
    phase    = 0;
    period   = 4;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 8);
        lead     = $urandom_range(2);
        period   = $urandom_range(40, 4);
        offset   = int'($urandom_range(16000)) - 8000;
        spread   = $urandom_range(400);
        noisy    = ($urandom_range(7) == 0);
        phase    = 0;
        for (int a = 0; a < NUM_AXES; a++)
          amp[a] = (a == lead) ? int'($urandom_range(20000, 500)) : int'($urandom_range(3000));
      end
      wave = 4 * phase - 2 * period;
      wave = (wave < 0) ? -wave : wave;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (noisy) begin
          s[a] = sample_t'($urandom);
        end else begin
          v = offset + amp[a] * (wave - period) / period
              + int'($urandom_range(2 * spread)) - spread;
          s[a] = (v > 32767) ? 16'sh7FFF : (v < -32768) ? 16'sh8000 : sample_t'(v);
        end
      end
      send_sample(s[0], s[1], s[2]);
      phase = (phase + 1) % period;
      seg_left--;
    end
  endtask

  // Runs on the register values left by reset; the crossing history starts at zero.
  task automatic test_first_sample();
    send_sample(16'sd1000, -16'sd1000, 16'sd3);
    send_sample(16'sh7FFF, 16'sh8000, -16'sd1);
    send_sample(-16'sd1, 16'sd0, 16'sh7FFF);
  endtask

  // Full-scale swings on x and y in opposite directions give equal thresholds, so x wins.
  task automatic test_full_swing();
    set_registers(16'hFFFF, 16'd11);
    repeat (4) send_sample(16'sh7FFF, 16'sh8000, 16'sd0);
    repeat (4) send_sample(16'sh8000, 16'sh7FFF, -16'sd1);
  endtask

  // With no minimum swing every axis qualifies, and one-sample windows close every time.
  task automatic test_zero_swing();
    sample_t ramp [6];
    ramp = '{16'sd0, 16'sd10000, 16'sd20000, 16'sh7FFF, 16'sh7FFF, -16'sd5};
    set_registers(16'd0, 16'd1);
    for (int i = 0; i < 6; i++) send_sample(ramp[i], -16'sd100, 16'sd5000);
  endtask

  // A square wave on z with short windows, so crossings fall across window boundaries.
  task automatic test_crossing();
    sample_t square [8];
    square = '{16'sd8000, 16'sd8000, -16'sd8000, -16'sd8000,
               16'sd8000, 16'sd8000, 16'sd8000, -16'sd8000};
    set_registers(16'd200, 16'd3);
    for (int i = 0; i < 8; i++) send_sample(16'sd10, -16'sd10, square[i]);
  endtask

  task automatic test_register_sweep();
    set_registers(16'd3000, 16'd50);
    send_gait(100);
    set_registers(16'd0, 16'd1);
    send_gait(100);
    set_registers(16'hFFFF, {8'($urandom), 8'd255});
    send_gait(100);
    // The sender holds off midway until every result has been transferred.
    set_registers(16'd150, 16'd6);
    send_gait(50);
    drain_results();
    send_gait(50);
    steady_in  = 1'b1;
    steady_out = 1'b1;
    set_registers(16'($urandom_range(4000)), 16'($urandom_range(40, 2)));
    send_gait(200);
    steady_in  = 1'b0;
    steady_out = 1'b0;
    set_registers(16'($urandom), {8'($urandom), 8'($urandom_range(255, 1))});
    send_gait(100);
  endtask

  // Shortening the window below the current position makes the counter wrap first.
  task automatic test_window_shrink();
    set_registers(16'd2500, 16'd200);
    send_gait(60);
    set_registers(16'd2500, {8'($urandom), 8'd5});
    send_gait(240);
  endtask

  // A window length of zero gives windows of 256 samples.
  task automatic test_window_wrap();
    set_registers(16'd1000, {8'($urandom), 8'd0});
    send_gait(400);
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_first_sample();
    test_full_swing();
    test_zero_swing();
    test_crossing();
    test_register_sweep();
    test_window_shrink();
    test_window_wrap();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: accel_step_detector_core.f
hdl/acc_step_pkg.sv
hdl/acc_step_fifo.sv
hdl/acc_step_filter.sv
hdl/acc_step_detect.sv
hdl/accel_step_detector_core.sv
dv/testbench.sv
